// ===== hdl/spiee_pkg.sv =====
// Shared types and constants for the SPI serial EEPROM slave core.
// Holds the opcodes, frame phase and command codes, and the structs passed between modules.
// No dependencies.
package spiee_pkg;

    // Instruction opcodes decoded from the first word of a frame.
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRSR  = 8'h01;

    // Block-protect levels held in the status register.
    localparam logic [1:0] BP_NONE    = 2'd0;
    localparam logic [1:0] BP_QUARTER = 2'd1;
    localparam logic [1:0] BP_HALF    = 2'd2;
    localparam logic [1:0] BP_ALL     = 2'd3;

    localparam logic [15:0] TICKS_RESET = 16'd5000;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_CS_RISE = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        PH_OPCODE    = 3'd0,
        PH_ADDR_HI   = 3'd1,
        PH_ADDR_LO   = 3'd2,
        PH_DATA      = 3'd3,
        PH_STATUS    = 3'd4,
        PH_WRSR_DATA = 3'd5,
        PH_DONE      = 3'd6,
        PH_IGNORE    = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_DATA   = 2'd1,
        WR_STATUS = 2'd2
    } t_wrote;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] wr_data;
    } t_mem_ctl;

    typedef struct packed {
        logic [7:0] miso;
        logic       from_mem;
        logic       wip;
        logic       wel;
        logic       rej;
    } t_result;

endpackage

// ===== hdl/spiee_mem.sv =====
// Cell array of the EEPROM: one write port, one registered read port.
// After reset a sweep fills every byte with 0xFF, one byte per cycle.
// Depends on spiee_pkg.
module spiee_mem import spiee_pkg::*; #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_addr,
    output logic [7:0]    o_rd_data,
    output logic          o_ready
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= 8'hFF;
        end else if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_active;

endmodule

// ===== hdl/spiee_ctrl.sv =====
// Frame decoder and status logic of the EEPROM slave: holds the frame state,
// pointer, latches and write-cycle timer, and works out one result per word.
// Depends on spiee_pkg.
module spiee_ctrl import spiee_pkg::*; #(
    parameter int ARRAY_BYTES = 8192,
    parameter int PAGE_BYTES  = 32,
    parameter int AW          = 13,
    parameter int CW          = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic [1:0]    i_command,
    input  logic [7:0]    i_mosi_byte,
    input  logic          i_cfg_wr,
    input  logic [15:0]   i_cfg_data,
    output t_mem_ctl      o_mem,
    output logic [AW-1:0] o_mem_addr,
    output t_result       o_res
);

    localparam logic [AW:0]   N_EXT     = (AW+1)'(ARRAY_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ARRAY_BYTES - 1);
    localparam logic [AW-1:0] PROT_QTR  = AW'(ARRAY_BYTES - ARRAY_BYTES / 4);
    localparam logic [AW-1:0] PROT_HALF = AW'(ARRAY_BYTES / 2);
    localparam logic [CW:0]   P_EXT     = (CW+1)'(PAGE_BYTES);
    localparam logic [CW-1:0] LAST_COL  = CW'(PAGE_BYTES - 1);

    // Residue tables: high byte times 256 modulo the array size and the page
    // size, and low byte modulo the page size.
    logic [AW-1:0] hi_mod_n [256];
    logic [CW-1:0] hi_mod_p [256];
    logic [CW-1:0] lo_mod_p [256];

    for (genvar g = 0; g < 256; g++) begin : g_tab
        localparam int HN = (g * 256) % ARRAY_BYTES;
        localparam int HP = (g * 256) % PAGE_BYTES;
        localparam int LP = g % PAGE_BYTES;
        assign hi_mod_n[g] = AW'(HN);
        assign hi_mod_p[g] = CW'(HP);
        assign lo_mod_p[g] = CW'(LP);
    end

    t_phase        r_phase,   n_phase;
    logic [7:0]    r_opcode,  n_opcode;
    logic [AW-1:0] r_ptr,     n_ptr;
    logic [CW-1:0] r_col,     n_col;
    logic          r_wel,     n_wel;
    logic          r_wip,     n_wip;
    logic [1:0]    r_bp,      n_bp;
    logic [1:0]    r_pend,    n_pend;
    logic [15:0]   r_cnt,     n_cnt;
    t_wrote        r_wrote,   n_wrote;
    logic [15:0]   r_ticks;

    logic [AW:0]   lo_sum;
    logic [AW-1:0] lo_addr;
    logic [15:0]   lo_addr16;
    logic [CW:0]   col_sum;
    logic [CW-1:0] lo_col;
    logic          prot;
    logic          op_known;
    logic [15:0]   cnt_dec;
    t_mem_ctl      mem;
    t_result       res;

    // Address low byte: pointer already holds the reduced high part.
    assign lo_sum    = {1'b0, r_ptr} + (AW+1)'(i_mosi_byte);
    assign lo_addr   = (lo_sum >= N_EXT) ? AW'(lo_sum - N_EXT) : lo_sum[AW-1:0];
    assign lo_addr16 = 16'(lo_addr);
    assign col_sum   = (CW+1)'(hi_mod_p[lo_addr16[15:8]]) + (CW+1)'(lo_mod_p[lo_addr16[7:0]]);
    assign lo_col    = (col_sum >= P_EXT) ? CW'(col_sum - P_EXT) : col_sum[CW-1:0];
    assign cnt_dec   = (r_cnt != 16'd0) ? r_cnt - 16'd1 : r_cnt;

    assign op_known = (i_mosi_byte == OP_READ) || (i_mosi_byte == OP_WRITE) ||
                      (i_mosi_byte == OP_WREN) || (i_mosi_byte == OP_WRDI) ||
                      (i_mosi_byte == OP_RDSR) || (i_mosi_byte == OP_WRSR);

    always_comb begin
        unique case (r_bp)
            BP_QUARTER: prot = (r_ptr >= PROT_QTR);
            BP_HALF:    prot = (r_ptr >= PROT_HALF);
            BP_ALL:     prot = 1'b1;
            default:    prot = 1'b0;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_ptr    = r_ptr;
        n_col    = r_col;
        n_wel    = r_wel;
        n_wip    = r_wip;
        n_bp     = r_bp;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_wrote  = r_wrote;
        mem      = '{wr_en: 1'b0, rd_en: 1'b0, wr_data: i_mosi_byte};
        res.miso     = 8'd0;
        res.from_mem = 1'b0;
        res.rej      = 1'b0;

        unique case (t_cmd'(i_command))
            CMD_BYTE: begin
                unique case (r_phase)
                    PH_OPCODE: begin
                        n_opcode = i_mosi_byte;
                        priority if (!op_known ||
                                     (r_wip && i_mosi_byte != OP_RDSR) ||
                                     ((i_mosi_byte == OP_WRITE || i_mosi_byte == OP_WRSR)
                                      && !r_wel)) begin
                            n_phase = PH_IGNORE;
                            res.rej = 1'b1;
                        end else if (i_mosi_byte == OP_READ || i_mosi_byte == OP_WRITE) begin
                            n_phase = PH_ADDR_HI;
                        end else if (i_mosi_byte == OP_RDSR) begin
                            n_phase = PH_STATUS;
                        end else if (i_mosi_byte == OP_WRSR) begin
                            n_phase = PH_WRSR_DATA;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_ADDR_HI: begin
                        n_ptr   = hi_mod_n[i_mosi_byte];
                        n_phase = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        n_ptr   = lo_addr;
                        n_col   = lo_col;
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        if (r_opcode == OP_READ) begin
                            mem.rd_en    = i_acc;
                            res.from_mem = 1'b1;
                            n_ptr = (r_ptr == LAST_ADDR) ? '0 : r_ptr + 1'b1;
                        end else begin
                            if (prot) begin
                                res.rej = 1'b1;
                            end else begin
                                mem.wr_en = i_acc;
                                n_wrote   = WR_DATA;
                            end
                            // The column wraps inside its page; a short last
                            // page wraps at the end of the array as well.
                            priority if (r_col == LAST_COL) begin
                                n_ptr = r_ptr - AW'(r_col);
                                n_col = '0;
                            end else if (r_ptr == LAST_ADDR) begin
                                n_ptr = '0;
                                n_col = '0;
                            end else begin
                                n_ptr = r_ptr + 1'b1;
                                n_col = r_col + 1'b1;
                            end
                        end
                    end
                    PH_STATUS: begin
                        res.miso = {4'd0, r_bp, r_wel, r_wip};
                    end
                    PH_WRSR_DATA: begin
                        n_pend  = i_mosi_byte[3:2];
                        n_wrote = WR_STATUS;
                        n_phase = PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_CS_RISE: begin
                if (r_phase == PH_DONE && r_opcode == OP_WREN) begin
                    n_wel = 1'b1;
                end
                if (r_phase == PH_DONE && r_opcode == OP_WRDI) begin
                    n_wel = 1'b0;
                end
                if (r_wrote != WR_NONE) begin
                    if (r_wrote == WR_STATUS) begin
                        n_bp = r_pend;
                    end
                    n_wip = 1'b1;
                    n_cnt = (r_ticks != 16'd0) ? r_ticks : 16'd1;
                    n_wel = 1'b0;
                end
                n_phase = PH_OPCODE;
                n_wrote = WR_NONE;
            end
            CMD_TICK: begin
                if (r_wip) begin
                    n_cnt = cnt_dec;
                    if (cnt_dec == 16'd0) begin
                        n_wip = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        res.wip = n_wip;
        res.wel = n_wel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_opcode <= 8'd0;
            r_ptr    <= '0;
            r_col    <= '0;
            r_wel    <= 1'b0;
            r_wip    <= 1'b0;
            r_bp     <= BP_NONE;
            r_pend   <= BP_NONE;
            r_cnt    <= 16'd0;
            r_wrote  <= WR_NONE;
        end else if (i_acc) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_ptr    <= n_ptr;
            r_col    <= n_col;
            r_wel    <= n_wel;
            r_wip    <= n_wip;
            r_bp     <= n_bp;
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
            r_wrote  <= n_wrote;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RESET;
        end else if (i_cfg_wr) begin
            r_ticks <= i_cfg_data;
        end
    end

    assign o_mem      = mem;
    assign o_mem_addr = r_ptr;
    assign o_res      = res;

endmodule

// ===== hdl/spi_eeprom_slave_core.sv =====
// Top level of the SPI serial EEPROM slave core.
// Depends on spiee_pkg, spiee_mem and spiee_ctrl.
//
// Usage:
// The input channel carries one word per frame event: a byte clocked in while
// chip select is low (command 0, with the byte on i_mosi_byte), the rise of
// chip select that ends the frame (command 1), or a timer tick (command 2).
// Every accepted word yields exactly one result word on the output channel:
// the byte shifted out to the master, the WIP and WEL flags after the word,
// and a flag that marks an ignored opcode or write data byte.
// The result word is valid on the cycle after the input word is accepted.
// One word can be accepted every cycle while the input is not stalled; the
// array has one write port and one registered read port, and each word does
// at most one read or one write. The input channel is stalled only during the
// fill sweep and while the output register holds a word that the receiver is
// stalling. After reset the block stalls its input while a sweep fills the
// cell array with 0xFF; the write-cycle length register may be written during
// that time. The configuration port is always ready and should only be
// written while no word is in flight.
module spi_eeprom_slave_core import spiee_pkg::*; #(
    parameter int ARRAY_BYTES = 8192,
    parameter int PAGE_BYTES  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_mosi_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_miso_byte,
    output logic        o_write_in_progress,
    output logic        o_write_enabled,
    output logic        o_rejected,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(ARRAY_BYTES);
    localparam int CW = $clog2(PAGE_BYTES);

    logic          acc;
    logic          mem_ready;
    logic [7:0]    mem_rd_data;
    t_mem_ctl      mem_ctl;
    logic [AW-1:0] mem_addr;
    t_result       res;
    logic          r_out_valid;
    t_result       r_res;

    // A word enters when the array sweep is done and the output register is
    // empty or being emptied on this edge.
    assign o_stall     = !mem_ready || (r_out_valid && i_stall);
    assign acc         = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    spiee_ctrl #(
        .ARRAY_BYTES (ARRAY_BYTES),
        .PAGE_BYTES  (PAGE_BYTES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_command   (i_command),
        .i_mosi_byte (i_mosi_byte),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_mem       (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_res       (res)
    );

    spiee_mem #(
        .DEPTH (ARRAY_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .o_rd_data (mem_rd_data),
        .o_ready   (mem_ready)
    );

    // Output register. Read data stays in the memory's read register, which
    // only loads on an accepted word, so it holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_miso_byte         = r_res.from_mem ? mem_rd_data : r_res.miso;
    assign o_write_in_progress = r_res.wip;
    assign o_write_enabled     = r_res.wel;
    assign o_rejected          = r_res.rej;

    // No word may enter while the fill sweep still owns the array.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mem_ready |-> !acc)
        else $error("word accepted during array fill sweep");

    // The array is written only on behalf of an accepted word.
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |-> acc)
        else $error("array write without an accepted word");

    // A data byte read from the array is never flagged as rejected.
    a_read_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.from_mem) |-> !r_res.rej)
        else $error("read data word flagged as rejected");

endmodule
